@@ rtl/playfair_decrypt_top_defines.svh @@
// assertion macros for the playfair decrypt block
// no dependencies; included by the controller and the datapath
`ifndef PLAYFAIR_DECRYPT_TOP_DEFINES_SVH
`define PLAYFAIR_DECRYPT_TOP_DEFINES_SVH
`ifndef SYNTH
`define PFD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pfd assertion failed");
`define PFD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pfd assertion failed");
`else
`define PFD_ASSERT(lbl, clk, rst, prop)
`define PFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/pfd_pkg.sv @@
// shared types and constants for the playfair decrypt block
// no dependencies
`default_nettype none

package pfd_pkg;

   localparam int GRID_SIDE_DEF = 5;
   localparam int LETTER_W      = 5;
   localparam int LETTERS       = 26;

   typedef logic [LETTER_W-1:0] letter_type;

   localparam letter_type LETTER_I    = 5'd8;
   localparam letter_type LETTER_J    = 5'd9;
   localparam letter_type LETTER_LAST = 5'd25;

   localparam logic OP_KEY     = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic key_write;
      logic fill_step;
      logic search_load;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic fill_done;
   } status_type;

   // square contents after reset: alphabet with j left out
   function automatic letter_type reset_letter(input int pos);
      if (pos < int'(LETTER_J)) begin
         return letter_type'(pos);
      end
      return letter_type'(pos + 1);
   endfunction

endpackage

`default_nettype wire

@@ rtl/pfd_datapath.sv @@
// key square storage, letter placement, digraph search and output register
// depends on pfd_pkg and playfair_decrypt_top_defines.svh
`default_nettype none
`include "playfair_decrypt_top_defines.svh"

module pfd_datapath import pfd_pkg::*; #(
   parameter int GRID_SIDE = GRID_SIDE_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire letter_type req_letter_a,
   input  wire letter_type req_letter_b,
   input  wire logic       req_key_first,
   output letter_type      rsp_plain_a,
   output letter_type      rsp_plain_b,
   output status_type      status
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int IDX_W = $clog2(GRID_SIDE);
   localparam int POS_W = $clog2(CELLS + 1);
   localparam logic [LETTERS-1:0] USED_RESET = LETTERS'(1) << LETTER_J;

   letter_type square_ff [CELLS];
   letter_type square_in [CELLS];
   logic [LETTERS-1:0] used_ff, used_in;
   logic [POS_W-1:0]   fill_ff, fill_in;
   letter_type         step_ff, step_in;

   logic [LETTERS-1:0] base_used;
   logic [POS_W-1:0]   base_fill;
   letter_type         place_letter;
   logic [LETTERS-1:0] letter_oh;
   logic               place_ok;

   letter_type         look_letter [2];
   logic [CELLS-1:0]   match [2];
   logic [CELLS-1:0]   first_hit [2];
   logic [IDX_W-1:0]   row_idx [2];
   logic [IDX_W-1:0]   col_idx [2];
   logic [IDX_W-1:0]   row_ff [2];
   logic [IDX_W-1:0]   col_ff [2];
   logic [IDX_W-1:0]   out_row [2];
   logic [IDX_W-1:0]   out_col [2];
   letter_type         pick [2];
   letter_type         plain_a_ff, plain_b_ff;

   function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] x);
      return (x == '0) ? IDX_W'(GRID_SIDE - 1) : x - 1'b1;
   endfunction

   // placement: one keyword letter or one alphabet step of the fill walk
   always_comb begin
      base_used    = used_ff;
      base_fill    = fill_ff;
      place_letter = step_ff;
      if (cmd.key_write) begin
         place_letter = req_letter_a;
         if (req_key_first) begin
            base_used = USED_RESET;
            base_fill = '0;
         end
      end
      for (int l = 0; l < LETTERS; l++) begin
         letter_oh[l] = (place_letter == LETTER_W'(l));
      end
      // letters beyond z give an empty one-hot and are dropped
      place_ok = (cmd.key_write || cmd.fill_step) && (|letter_oh)
                 && !(|(letter_oh & base_used)) && (base_fill < POS_W'(CELLS));
      used_in = place_ok ? (base_used | letter_oh) : base_used;
      fill_in = base_fill + POS_W'(place_ok);
      for (int p = 0; p < CELLS; p++) begin
         square_in[p] = square_ff[p];
         if (place_ok && base_fill == POS_W'(p)) begin
            square_in[p] = place_letter;
         end
      end
      if (cmd.key_write) begin
         step_in = '0;
      end else if (cmd.fill_step) begin
         step_in = step_ff + 1'b1;
      end else begin
         step_in = step_ff;
      end
   end

   assign status.fill_done = (step_ff == LETTER_LAST);

   // search: first matching cell in row-major order, row 0 column 0 when absent
   always_comb begin
      look_letter[0] = req_letter_a;
      look_letter[1] = req_letter_b;
      for (int lane = 0; lane < 2; lane++) begin
         if (look_letter[lane] == LETTER_J) begin
            look_letter[lane] = LETTER_I;
         end
         for (int p = 0; p < CELLS; p++) begin
            match[lane][p] = (square_ff[p] == look_letter[lane]);
         end
         first_hit[lane] = match[lane] & (~match[lane] + 1'b1);
         row_idx[lane] = '0;
         col_idx[lane] = '0;
         for (int r = 0; r < GRID_SIDE; r++) begin
            for (int c = 0; c < GRID_SIDE; c++) begin
               if (first_hit[lane][r*GRID_SIDE + c]) begin
                  row_idx[lane] = row_idx[lane] | IDX_W'(r);
                  col_idx[lane] = col_idx[lane] | IDX_W'(c);
               end
            end
         end
      end
   end

   // playfair rules on the registered positions
   always_comb begin
      for (int lane = 0; lane < 2; lane++) begin
         if (row_ff[0] == row_ff[1]) begin
            out_row[lane] = row_ff[lane];
            out_col[lane] = step_back(col_ff[lane]);
         end else if (col_ff[0] == col_ff[1]) begin
            out_row[lane] = step_back(row_ff[lane]);
            out_col[lane] = col_ff[lane];
         end else begin
            out_row[lane] = row_ff[lane];
            out_col[lane] = col_ff[1 - lane];
         end
         pick[lane] = '0;
         for (int r = 0; r < GRID_SIDE; r++) begin
            for (int c = 0; c < GRID_SIDE; c++) begin
               if (out_row[lane] == IDX_W'(r) && out_col[lane] == IDX_W'(c)) begin
                  pick[lane] = square_ff[r*GRID_SIDE + c];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < CELLS; p++) begin
            square_ff[p] <= reset_letter(p);
         end
         used_ff <= USED_RESET;
         fill_ff <= '0;
         step_ff <= '0;
      end else begin
         for (int p = 0; p < CELLS; p++) begin
            square_ff[p] <= square_in[p];
         end
         used_ff <= used_in;
         fill_ff <= fill_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_load) begin
         row_ff[0] <= row_idx[0];
         row_ff[1] <= row_idx[1];
         col_ff[0] <= col_idx[0];
         col_ff[1] <= col_idx[1];
      end
      if (cmd.out_load) begin
         plain_a_ff <= pick[0];
         plain_b_ff <= pick[1];
      end
   end

   assign rsp_plain_a = plain_a_ff;
   assign rsp_plain_b = plain_b_ff;

   `PFD_ASSERT_ALWAYS(a_fill_bound, clock, reset || fill_ff <= POS_W'(CELLS))
   `PFD_ASSERT(a_fill_steady, clock, reset, !(cmd.key_write || cmd.fill_step) |=> $stable(fill_ff))
   `PFD_ASSERT(a_j_kept_used, clock, reset, used_ff[LETTER_J])

endmodule

`default_nettype wire

@@ rtl/pfd_ctrl.sv @@
// controller state machine: handshakes and datapath commands
// depends on pfd_pkg and playfair_decrypt_top_defines.svh
`default_nettype none
`include "playfair_decrypt_top_defines.svh"

module pfd_ctrl import pfd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_operation,
   input  wire logic       req_key_last,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output logic            req_stall,
   output logic            rsp_valid,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_KEY) begin
                  cmd.key_write = 1'b1;
                  if (req_key_last) begin
                     state_in = ST_FILL;
                  end
               end else begin
                  cmd.search_load = 1'b1;
                  state_in        = ST_OUT;
               end
            end
         end
         ST_FILL: begin
            // one alphabet letter per cycle
            cmd.fill_step = 1'b1;
            if (status.fill_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `PFD_ASSERT(a_out_waits, clock, reset, (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> state_ff == ST_OUT)
   `PFD_ASSERT(a_decrypt_to_out, clock, reset, (req_valid && !req_stall && req_operation == OP_DECRYPT) |=> state_ff == ST_OUT)
   `PFD_ASSERT(a_last_to_fill, clock, reset, (req_valid && !req_stall && req_operation == OP_KEY && req_key_last) |=> state_ff == ST_FILL)
   `PFD_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))

endmodule

`default_nettype wire

@@ rtl/playfair_decrypt_top.sv @@
// playfair 5x5 key square builder and digraph decryptor
// decrypt: positions registered, then output register loaded; requests stall until then
// keyword letter: placed at once; key_last adds the alphabet fill walk (one letter each)
// the output register lets the next item in while a result still waits
// reset is synchronous: square returns to the alphabet without j, fill position zero
`default_nettype none

module playfair_decrypt_top import pfd_pkg::*; #(
   parameter int GRID_SIDE = GRID_SIDE_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_operation,
   input  wire letter_type req_letter_a,
   input  wire letter_type req_letter_b,
   input  wire logic       req_key_first,
   input  wire logic       req_key_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output letter_type      rsp_plain_a,
   output letter_type      rsp_plain_b
);

   cmd_type    cmd;
   status_type status;

   pfd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_key_last  (req_key_last),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd)
   );

   pfd_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_letter_a  (req_letter_a),
      .req_letter_b  (req_letter_b),
      .req_key_first (req_key_first),
      .rsp_plain_a   (rsp_plain_a),
      .rsp_plain_b   (rsp_plain_b),
      .status        (status)
   );

endmodule

`default_nettype wire
